/* sv/clnf_pkg.sv */
// Package for the character LCD number formatter.
// Holds the state and format codes and the LCD byte constants; no dependencies.
`default_nettype none
package clnf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CMD,
        ST_PRE,
        ST_DIGIT
    } t_state;

    typedef enum logic [2:0] {
        OP_CHAR = 3'd0,
        OP_UDEC = 3'd1,
        OP_SDEC = 3'd2,
        OP_HEX  = 3'd3,
        OP_BIN  = 3'd4
    } t_op;

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] LINE2_OFFS   = 8'h40;
    localparam logic [7:0] ASC_ZERO     = 8'h30;
    localparam logic [7:0] ASC_HEX_BASE = 8'h37;
    localparam logic [7:0] ASC_PLUS     = 8'h2B;
    localparam logic [7:0] ASC_MINUS    = 8'h2D;
    localparam logic [1:0] LINE_FIRST   = 2'd1;
    localparam int         BIN_W        = 16;
    localparam int         BCD_DIGITS   = 5;

endpackage
`default_nettype wire

/* sv/clnf_ifs.sv */
// Valid/ready channel interfaces for the request and LCD write words.
// No dependencies.
`default_nettype none
interface clnf_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [1:0] line;
    logic [5:0] column;
    logic [7:0] char_code;
    logic [15:0] value;
    logic [4:0] digit_count;

    modport source (output valid, op, line, column, char_code, value, digit_count,
                    input ready);
    modport sink   (input valid, op, line, column, char_code, value, digit_count,
                    output ready);
endinterface

interface clnf_out_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last_item;

    modport source (output valid, reg_select, bus_byte, last_item, input ready);
    modport sink   (input valid, reg_select, bus_byte, last_item, output ready);
endinterface
`default_nettype wire

/* sv/char_lcd_number_formatter_core.sv */
// Character LCD number formatter: one request in, a run of LCD bus writes out.
// Steps: the request is accepted, then 16 binary-to-BCD shift-add-3 steps run
// in the shared converter, then one write word per cycle the output is free.
// Ready only when idle, so no new request is taken before the last write word is issued.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops o_wr.valid.
// Depends on clnf_pkg and clnf_ifs.
`default_nettype none
module char_lcd_number_formatter_core #(
    parameter int MAX_DIGITS = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    clnf_in_if.sink       i_req,
    clnf_out_if.source    o_wr
);
    import clnf_pkg::*;

    localparam logic [4:0] MaxCnt = 5'(MAX_DIGITS);

    t_state r_state, n_state;
    logic [2:0]  r_op;
    logic [7:0]  r_cmd;
    logic [7:0]  r_char;
    logic [15:0] r_mag;
    logic [15:0] r_shift;
    logic [4*BCD_DIGITS-1:0] r_bcd;
    logic [3:0]  r_step;
    logic [4:0]  r_pos;
    logic        r_neg;
    logic        r_out_valid;
    logic        r_out_rs;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        w_accept;
    logic        w_free;
    logic        w_emit;
    logic        w_emit_rs;
    logic [7:0]  w_emit_byte;
    logic        w_emit_last;
    logic        w_has_digits;
    logic [3:0]  w_idx;
    logic [3:0]  w_digit;
    logic [15:0] w_hex_sh;
    logic [4*BCD_DIGITS-1:0] w_bcd_adj;
    logic [7:0]  w_addr;
    logic [4:0]  w_cnt;

    assign i_req.ready  = (r_state == ST_IDLE);
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_free       = !r_out_valid || o_wr.ready;
    assign w_has_digits = (r_op == OP_UDEC || r_op == OP_SDEC || r_op == OP_HEX
                           || r_op == OP_BIN) && (r_pos != 5'd0);

    assign w_addr = 8'({2'b00, i_req.column} + 8'hFF);
    assign w_cnt  = (i_req.digit_count > MaxCnt) ? MaxCnt : i_req.digit_count;

    // shift-add-3 correction of each BCD digit
    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            w_bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ?
                                  4'(r_bcd[4*k +: 4] + 4'd3) : r_bcd[4*k +: 4];
        end
    end

    assign w_idx    = 4'(r_pos - 5'd1);
    assign w_hex_sh = r_mag >> {w_idx[1:0], 2'b00};

    always_comb begin
        w_digit = 4'd0;
        if (r_op == OP_HEX) begin
            w_digit = (w_idx < 4'd4) ? w_hex_sh[3:0] : 4'd0;
        end else if (r_op == OP_BIN) begin
            w_digit = {3'b000, r_mag[w_idx]};
        end else begin
            unique case (w_idx)
                4'd0:    w_digit = r_bcd[3:0];
                4'd1:    w_digit = r_bcd[7:4];
                4'd2:    w_digit = r_bcd[11:8];
                4'd3:    w_digit = r_bcd[15:12];
                4'd4:    w_digit = r_bcd[19:16];
                default: w_digit = 4'd0;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_CONV;
            ST_CONV:  if (r_step == 4'd15) n_state = ST_CMD;
            ST_CMD: begin
                if (w_free) begin
                    if (r_op == OP_CHAR || r_op == OP_SDEC) n_state = ST_PRE;
                    else if (w_has_digits) n_state = ST_DIGIT;
                    else n_state = ST_IDLE;
                end
            end
            ST_PRE: begin
                if (w_free) n_state = w_has_digits ? ST_DIGIT : ST_IDLE;
            end
            ST_DIGIT: if (w_free && r_pos == 5'd1) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // write word to emit
    always_comb begin
        w_emit      = 1'b0;
        w_emit_rs   = 1'b1;
        w_emit_byte = r_char;
        w_emit_last = 1'b0;
        unique case (r_state)
            ST_CMD: begin
                w_emit      = 1'b1;
                w_emit_rs   = 1'b0;
                w_emit_byte = r_cmd;
                w_emit_last = !(r_op == OP_CHAR || r_op == OP_SDEC) && !w_has_digits;
            end
            ST_PRE: begin
                w_emit      = 1'b1;
                w_emit_byte = (r_op == OP_CHAR) ? r_char :
                              (r_neg ? ASC_MINUS : ASC_PLUS);
                w_emit_last = !w_has_digits;
            end
            ST_DIGIT: begin
                w_emit      = 1'b1;
                w_emit_byte = (w_digit < 4'd10) ? 8'(ASC_ZERO + {4'd0, w_digit}) :
                                                  8'(ASC_HEX_BASE + {4'd0, w_digit});
                w_emit_last = (r_pos == 5'd1);
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit && w_free) r_out_valid <= 1'b1;
            else if (o_wr.ready)  r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_req.op;
            r_char <= i_req.char_code;
            r_pos  <= w_cnt;
            r_step <= 4'd0;
            r_bcd  <= '0;
            r_cmd  <= (i_req.line == LINE_FIRST) ? (CMD_SET_ADDR | w_addr) :
                      (CMD_SET_ADDR | 8'(w_addr + LINE2_OFFS));
            r_neg  <= (i_req.op == OP_SDEC) && i_req.value[15];
            if (i_req.op == OP_SDEC && i_req.value[15]) begin
                r_mag   <= 16'(~i_req.value + 16'd1);
                r_shift <= 16'(~i_req.value + 16'd1);
            end else begin
                r_mag   <= i_req.value;
                r_shift <= i_req.value;
            end
        end else if (r_state == ST_CONV) begin
            r_bcd   <= {w_bcd_adj[4*BCD_DIGITS-2:0], r_shift[BIN_W-1]};
            r_shift <= {r_shift[BIN_W-2:0], 1'b0};
            r_step  <= 4'(r_step + 4'd1);
        end else if (r_state == ST_DIGIT && w_free) begin
            r_pos <= 5'(r_pos - 5'd1);
        end
        if (w_emit && w_free) begin
            r_out_rs   <= w_emit_rs;
            r_out_byte <= w_emit_byte;
            r_out_last <= w_emit_last;
        end
    end

    assign o_wr.valid      = r_out_valid;
    assign o_wr.reg_select = r_out_rs;
    assign o_wr.bus_byte   = r_out_byte;
    assign o_wr.last_item  = r_out_last;

endmodule
`default_nettype wire

/* dv/clnf_write_checker.sv */
// Watches the request and LCD write channels of the number formatter, predicts
// the write words for each accepted request and compares them in order.
// Depends on clnf_pkg and clnf_ifs.
`default_nettype none
module clnf_write_checker #(
    parameter int MAX_DIGITS = 16
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    clnf_in_if    i_req,
    clnf_out_if   i_wr,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_writes_checked
);
    import clnf_pkg::*;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_byte;
        logic       last_item;
    } t_lcd_write;

    t_lcd_write lcd_writes_due[$];
    int         fail_cnt = 0;
    int         checked_cnt = 0;

    function automatic void queue_lcd_write(input logic rs, input logic [7:0] data);
        t_lcd_write w;
        w.reg_select = rs;
        w.bus_byte   = data;
        w.last_item  = 1'b0;
        lcd_writes_due.push_back(w);
    endfunction

    function automatic void format_request(
        input logic [2:0]  op,
        input logic [1:0]  line,
        input logic [5:0]  column,
        input logic [7:0]  char_code,
        input logic [15:0] value,
        input logic [4:0]  digit_count
    );
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [16:0] mag;
        logic [16:0] rest;
        int          base;
        int          cnt;
        int          dig;
        t_lcd_write  tail;
        addr = {2'b00, column} - 8'd1;
        cmd  = (line == LINE_FIRST) ? (CMD_SET_ADDR | addr)
                                    : (CMD_SET_ADDR | (addr + LINE2_OFFS));
        cnt  = (digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(digit_count);
        mag  = {1'b0, value};
        base = 10;
        queue_lcd_write(1'b0, cmd);
        case (op)
            OP_CHAR: begin
                queue_lcd_write(1'b1, char_code);
                cnt = 0;
            end
            OP_UDEC: base = 10;
            OP_SDEC: begin
                if (value[15]) begin
                    queue_lcd_write(1'b1, ASC_MINUS);
                    mag = 17'h10000 - {1'b0, value};
                end else begin
                    queue_lcd_write(1'b1, ASC_PLUS);
                end
            end
            OP_HEX:  base = 16;
            OP_BIN:  base = 2;
            default: cnt = 0;
        endcase
        // most significant digit first, positions past the value give zero
        for (int p = cnt - 1; p >= 0; p--) begin
            rest = mag;
            repeat (p) rest = 17'(rest / base);
            dig = int'(rest) % base;
            queue_lcd_write(1'b1, (dig < 10) ? 8'(ASC_ZERO + dig) : 8'(ASC_HEX_BASE + dig));
        end
        tail = lcd_writes_due.pop_back();
        tail.last_item = 1'b1;
        lcd_writes_due.push_back(tail);
    endfunction

    always @(posedge i_clk) begin
        t_lcd_write got;
        t_lcd_write want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                format_request(i_req.op, i_req.line, i_req.column, i_req.char_code,
                               i_req.value, i_req.digit_count);
            end
            if (i_wr.valid && i_wr.ready) begin
                got.reg_select = i_wr.reg_select;
                got.bus_byte   = i_wr.bus_byte;
                got.last_item  = i_wr.last_item;
                checked_cnt++;
                if (lcd_writes_due.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected write word rs=%0d byte=%02h last=%0d",
                             $time, got.reg_select, got.bus_byte, got.last_item);
                end else begin
                    want = lcd_writes_due.pop_front();
                    if (got.reg_select !== want.reg_select || got.bus_byte !== want.bus_byte
                        || got.last_item !== want.last_item) begin
                        fail_cnt++;
                        $display("%0t: write mismatch: expected rs=%0d byte=%02h last=%0d,",
                                 $time, want.reg_select, want.bus_byte, want.last_item,
                                 " got rs=%0d byte=%02h last=%0d",
                                 got.reg_select, got.bus_byte, got.last_item);
                    end
                end
            end
        end
        o_pending        <= lcd_writes_due.size();
        o_fail_count     <= fail_cnt;
        o_writes_checked <= checked_cnt;
    end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Top of the number formatter testbench: clock, reset, request stimulus and
// write-side pacing; checking lives in clnf_write_checker.
// Depends on clnf_pkg, clnf_ifs, char_lcd_number_formatter_core.
`default_nettype none
module tb_top;
    import clnf_pkg::*;

    localparam int MAX_DIGITS     = 16;
    localparam int RAND_PER_PHASE = 120;
    localparam int MAX_GAP        = 30;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef enum int {
        PACE_FULL,
        PACE_TX_IDLE,
        PACE_RX_STALL,
        PACE_BOTH
    } t_pace;

    logic clk;
    logic rst_n;
    logic rx_ready = 1'b0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    int   fail_count;
    int   pending;
    int   writes_checked;
    int   idle_cycles = 0;
    int   op_hits[8];
    int   reqs_sent = 0;

    clnf_in_if  req_ch();
    clnf_out_if wr_ch();

    char_lcd_number_formatter_core #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_wr    (wr_ch)
    );

    clnf_write_checker #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req            (req_ch),
        .i_wr             (wr_ch),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_writes_checked (writes_checked)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    assign wr_ch.ready = rx_ready;

    always @(posedge clk) begin
        rx_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (wr_ch.valid && wr_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles", $time, idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic set_pace(input t_pace p);
        tx_idle_pct  <= (p == PACE_TX_IDLE) ? 65 : (p == PACE_BOTH) ? 14 : 0;
        rx_stall_pct <= (p == PACE_RX_STALL) ? 65 : (p == PACE_BOTH) ? 14 : 0;
    endtask

    task automatic send_req(
        input logic [2:0]  op,
        input logic [1:0]  line,
        input logic [5:0]  column,
        input logic [7:0]  char_code,
        input logic [15:0] value,
        input logic [4:0]  digit_count
    );
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.line        <= line;
        req_ch.column      <= column;
        req_ch.char_code   <= char_code;
        req_ch.value       <= value;
        req_ch.digit_count <= digit_count;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        op_hits[op]++;
        reqs_sent++;
    endtask

    // pause the sender until every predicted write has been seen
    task automatic drain_writes();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random_req();
        logic [2:0]  op;
        logic [1:0]  line;
        logic [5:0]  column;
        logic [15:0] value;
        logic [4:0]  digit_count;
        int          r;
        op     = ($urandom_range(99) < 90) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
        line   = ($urandom_range(99) < 85) ? 2'($urandom_range(2, 1)) : 2'($urandom_range(3));
        column = ($urandom_range(99) < 85) ? 6'($urandom_range(40, 1)) : 6'($urandom_range(63));
        r = $urandom_range(99);
        if (r < 60) begin
            digit_count = 5'($urandom_range(7));
        end else if (r < 90) begin
            digit_count = 5'($urandom_range(16, 8));
        end else begin
            digit_count = 5'($urandom_range(31, 17));
        end
        case ($urandom_range(3))
            0: value = 16'($urandom);
            1: value = 16'($urandom_range(15));
            2: begin
                case ($urandom_range(3))
                    0: value = 16'h0000;
                    1: value = 16'h7FFF;
                    2: value = 16'h8000;
                    default: value = 16'hFFFF;
                endcase
            end
            default: value = 16'($urandom_range(16'hFFFF, 16'hFF00));
        endcase
        send_req(op, line, column, 8'($urandom), value, digit_count);
    endtask

    initial begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_CHAR;
        req_ch.line        = LINE_FIRST;
        req_ch.column      = 6'd1;
        req_ch.char_code   = 8'h00;
        req_ch.value       = 16'h0000;
        req_ch.digit_count = 5'd0;
        foreach (op_hits[i]) op_hits[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(OP_CHAR, LINE_FIRST, 6'd1,  8'h00, 16'h0000, 5'd0);
        send_req(OP_CHAR, 2'd2,       6'd40, 8'hFF, 16'hFFFF, 5'd31);
        send_req(OP_UDEC, LINE_FIRST, 6'd5,  8'h00, 16'hFFFF, 5'd5);
        send_req(OP_UDEC, 2'd2,       6'd1,  8'h00, 16'h0000, 5'd16);
        send_req(OP_UDEC, LINE_FIRST, 6'd9,  8'h00, 16'd1234, 5'd0);
        send_req(OP_UDEC, LINE_FIRST, 6'd3,  8'h00, 16'd40000, 5'd17);
        send_req(OP_SDEC, LINE_FIRST, 6'd2,  8'h00, 16'h0000, 5'd5);
        send_req(OP_SDEC, 2'd2,       6'd2,  8'h00, 16'h8000, 5'd5);
        send_req(OP_SDEC, LINE_FIRST, 6'd7,  8'h00, 16'h7FFF, 5'd6);
        send_req(OP_SDEC, 2'd2,       6'd7,  8'h00, 16'hFFFF, 5'd0);
        send_req(OP_SDEC, LINE_FIRST, 6'd11, 8'h00, 16'hFFFF, 5'd3);
        send_req(OP_HEX,  LINE_FIRST, 6'd12, 8'h00, 16'hABCD, 5'd4);
        send_req(OP_HEX,  2'd2,       6'd13, 8'h00, 16'h1234, 5'd16);
        send_req(OP_HEX,  LINE_FIRST, 6'd14, 8'h00, 16'hFFFF, 5'd20);
        send_req(OP_BIN,  2'd2,       6'd15, 8'h00, 16'hA5A5, 5'd16);
        send_req(OP_BIN,  LINE_FIRST, 6'd16, 8'h00, 16'h0001, 5'd31);
        send_req(OP_CHAR, LINE_FIRST, 6'd0,  8'h41, 16'h0000, 5'd0);
        send_req(OP_UDEC, 2'd2,       6'd0,  8'h00, 16'd7,    5'd1);
        send_req(OP_CHAR, 2'd3,       6'd63, 8'h5A, 16'h0000, 5'd0);
        send_req(OP_HEX,  2'd0,       6'd20, 8'h00, 16'h00F0, 5'd2);
        for (int u = OP_BIN + 1; u < 8; u++) begin
            send_req(3'(u), LINE_FIRST, 6'd21, 8'h33, 16'h5555, 5'd4);
        end
        drain_writes();

        for (int p = PACE_FULL; p <= PACE_BOTH; p++) begin
            set_pace(t_pace'(p));
            repeat (RAND_PER_PHASE) send_random_req();
            drain_writes();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d requests: %0d char, %0d udec, %0d sdec, %0d hex, %0d bin,",
                 reqs_sent, op_hits[OP_CHAR], op_hits[OP_UDEC], op_hits[OP_SDEC],
                 op_hits[OP_HEX], op_hits[OP_BIN],
                 " %0d bad op", op_hits[5] + op_hits[6] + op_hits[7]);
        $display("%0d write words checked with free, idle-sender, stalled and mixed pacing",
                 writes_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
sv/clnf_pkg.sv
sv/clnf_ifs.sv
sv/char_lcd_number_formatter_core.sv
dv/clnf_write_checker.sv
dv/tb_top.sv
